// ===== design/bda_pkg.sv =====
package bda_pkg;

    // Operand and result geometry
    localparam int WORD_W     = 64;
    localparam int NUM_DIGITS = 20;
    localparam int DIGIT_W    = 4;
    localparam int CHAR_W     = 8;
    localparam int BIT_CNT_W  = $clog2(WORD_W);
    localparam int REM_W      = $clog2(NUM_DIGITS + 1);

    // ASCII codes
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

    // Digit cell commands
    typedef logic [1:0] cell_cmd_t;
    localparam cell_cmd_t CMD_HOLD   = 2'd0;
    localparam cell_cmd_t CMD_CLEAR  = 2'd1;
    localparam cell_cmd_t CMD_DABBLE = 2'd2;
    localparam cell_cmd_t CMD_SHIFT  = 2'd3;

    typedef logic [DIGIT_W-1:0] digit_t;

endpackage

// ===== design/bda_cell.sv =====
// One BCD digit of the double-dabble chain.
// DABBLE: add 3 if >= 5, then shift left taking the carry from the lower digit.
// SHIFT:  take the lower neighbor's digit (moves the number up by one digit).
module bda_cell
(
    input  logic               clk,
    input  bda_pkg::cell_cmd_t cmd,
    input  logic               carry_in,
    input  bda_pkg::digit_t    digit_in,
    output logic               carry_out,
    output bda_pkg::digit_t    digit
);

    bda_pkg::digit_t digit_reg;
    bda_pkg::digit_t digit_next;
    bda_pkg::digit_t adjusted;

    // Add-3 correction; the carry depends only on this digit, so no ripple
    always_comb
    begin
        if (digit_reg >= bda_pkg::digit_t'(5))
        begin
            adjusted = digit_reg + bda_pkg::digit_t'(3);
        end
        else
        begin
            adjusted = digit_reg;
        end
    end

    assign carry_out = adjusted[bda_pkg::DIGIT_W-1];

    always_comb
    begin
        case (cmd)
            bda_pkg::CMD_CLEAR:  digit_next = '0;
            bda_pkg::CMD_DABBLE: digit_next = {adjusted[bda_pkg::DIGIT_W-2:0], carry_in};
            bda_pkg::CMD_SHIFT:  digit_next = digit_in;
            default:             digit_next = digit_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
    end

    assign digit = digit_reg;

endmodule

// ===== design/binary_to_decimal_ascii_unit.sv =====
// Channel   Ports                        Handshake
// request   start, op, value             taken when start & !busy
// result    strobe, text_char, last      a one-cycle strobe per character, no back-pressure
//
// busy stays high while a request is converted: a double-dabble step for each of the 64
// magnitude bits through the 20 digit cells (one input bit per cycle), a sign step for
// a negative value, then a scan down from the top cell that drops leading zeros and
// picks one digit per cycle. A character is strobed the cycle after it is picked, so the
// last one shows in the first idle cycle, where the next request may already be taken.
// rst_n clears the control state; the digit cells need no reset.
module binary_to_decimal_ascii_unit
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          op,
    input  logic [bda_pkg::WORD_W-1:0]    value,
    output logic                          strobe,
    output logic [bda_pkg::CHAR_W-1:0]    text_char,
    output logic                          last
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CONV = 3'd1;
    localparam logic [2:0] ST_SIGN = 3'd2;
    localparam logic [2:0] ST_SKIP = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;

    localparam int TOP = bda_pkg::NUM_DIGITS - 1;

    logic [2:0]                       state_reg, state_next;
    logic [bda_pkg::WORD_W-1:0]       mag_reg, mag_next;
    logic                             neg_reg, neg_next;
    logic [bda_pkg::BIT_CNT_W-1:0]    cnt_reg, cnt_next;
    logic [bda_pkg::REM_W-1:0]        rem_reg, rem_next;
    logic                             strobe_reg, strobe_next;
    logic [bda_pkg::CHAR_W-1:0]       char_reg, char_next;
    logic                             last_reg, last_next;
    bda_pkg::cell_cmd_t               cmd;
    logic                             accept;
    logic                             is_neg;
    logic [bda_pkg::NUM_DIGITS-1:0]   carry;
    bda_pkg::digit_t                  digits [bda_pkg::NUM_DIGITS];
    logic [bda_pkg::CHAR_W-1:0]       top_char;

    assign accept   = start && (state_reg == ST_IDLE);
    assign is_neg   = op && value[bda_pkg::WORD_W-1];
    assign top_char = bda_pkg::CHAR_ZERO
                    + {{(bda_pkg::CHAR_W-bda_pkg::DIGIT_W){1'b0}}, digits[TOP]};

    // Digit cell chain: cell 0 takes the next magnitude bit, each cell feeds the one above
    genvar gi;
    generate
        for (gi = 0; gi < bda_pkg::NUM_DIGITS; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_first
                bda_cell u_cell
                (
                    .clk       (clk),
                    .cmd       (cmd),
                    .carry_in  (mag_reg[bda_pkg::WORD_W-1]),
                    .digit_in  ('0),
                    .carry_out (carry[gi]),
                    .digit     (digits[gi])
                );
            end
            else
            begin : g_next
                bda_cell u_cell
                (
                    .clk       (clk),
                    .cmd       (cmd),
                    .carry_in  (carry[gi-1]),
                    .digit_in  (digits[gi-1]),
                    .carry_out (carry[gi]),
                    .digit     (digits[gi])
                );
            end
        end
    endgenerate

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        mag_next    = mag_reg;
        neg_next    = neg_reg;
        cnt_next    = cnt_reg;
        rem_next    = rem_reg;
        strobe_next = 1'b0;
        char_next   = char_reg;
        last_next   = last_reg;
        cmd         = bda_pkg::CMD_HOLD;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd        = bda_pkg::CMD_CLEAR;
                    neg_next   = is_neg;
                    mag_next   = is_neg ? (~value + bda_pkg::WORD_W'(1)) : value;
                    cnt_next   = '0;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                cmd      = bda_pkg::CMD_DABBLE;
                mag_next = {mag_reg[bda_pkg::WORD_W-2:0], 1'b0};
                cnt_next = cnt_reg + bda_pkg::BIT_CNT_W'(1);
                rem_next = bda_pkg::REM_W'(bda_pkg::NUM_DIGITS);
                if (cnt_reg == bda_pkg::BIT_CNT_W'(bda_pkg::WORD_W - 1))
                begin
                    state_next = neg_reg ? ST_SIGN : ST_SKIP;
                end
            end
            ST_SIGN:
            begin
                strobe_next = 1'b1;
                char_next   = bda_pkg::CHAR_MINUS;
                last_next   = 1'b0;
                state_next  = ST_SKIP;
            end
            ST_SKIP, ST_EMIT:
            begin
                cmd = bda_pkg::CMD_SHIFT;
                rem_next = rem_reg - bda_pkg::REM_W'(1);
                if (state_reg == ST_SKIP && digits[TOP] == '0
                    && rem_reg != bda_pkg::REM_W'(1))
                begin
                    // leading zero: drop it
                end
                else
                begin
                    strobe_next = 1'b1;
                    char_next   = top_char;
                    last_next   = (rem_reg == bda_pkg::REM_W'(1));
                    state_next  = (rem_reg == bda_pkg::REM_W'(1)) ? ST_IDLE : ST_EMIT;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        mag_reg  <= mag_next;
        neg_reg  <= neg_next;
        cnt_reg  <= cnt_next;
        rem_reg  <= rem_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign busy      = (state_reg != ST_IDLE);
    assign strobe    = strobe_reg;
    assign text_char = char_reg;
    assign last      = last_reg;

endmodule
